>>> rtl/core/utf8_to_latin1_decoder_assert.svh
// Assertion macros for the UTF-8 to 8-bit character decoder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef UTF8_TO_LATIN1_DECODER_ASSERT_SVH
`define UTF8_TO_LATIN1_DECODER_ASSERT_SVH

// check cons in the same cycle as ante
`define U2L_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define U2L_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/u2l_pkg.sv
// Shared types, constants and helpers for the UTF-8 to 8-bit character decoder.
// No dependencies.
package u2l_pkg;

    localparam int          QUEUE_DEPTH_DEF = 2;
    localparam int          MAX_RESULTS     = 4;
    localparam logic [7:0]  REPL_RESET      = 8'h3F;

    localparam logic [1:0]  HELD_NONE  = 2'd0;
    localparam logic [1:0]  HELD_LEAD  = 2'd1;
    localparam logic [1:0]  HELD_ONE   = 2'd2;
    localparam logic [1:0]  HELD_TWO   = 2'd3;

    localparam logic [1:0]  NEED_NONE  = 2'd0;
    localparam logic [1:0]  NEED_ONE   = 2'd1;
    localparam logic [1:0]  NEED_TWO   = 2'd2;
    localparam logic [1:0]  NEED_THREE = 2'd3;

    localparam logic [7:0]  NUL_BYTE   = 8'h00;

    typedef logic [7:0] char_t;

    typedef struct packed {
        logic [1:0]                    last_idx;
        logic                          eot;
        logic [MAX_RESULTS-1:0][7:0]   chars;
    } run_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic logic [1:0] lead_need(input logic [7:0] b);
        logic [1:0] n;
        n = NEED_NONE;
        if ((b & 8'hE0) == 8'hC0)
            n = NEED_ONE;
        else if ((b & 8'hF0) == 8'hE0)
            n = NEED_TWO;
        else if ((b & 8'hF8) == 8'hF0)
            n = NEED_THREE;
        return n;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & 8'hC0) == 8'h80;
    endfunction

endpackage

>>> rtl/core/u2l_front.sv
// Front part: accepts input bytes, tracks the held sequence, builds result runs.
// Depends on u2l_pkg.
module u2l_front
    import u2l_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  char_t       repl_char,
    input  q_stat_t     q_stat,
    output logic        push,
    output run_t        push_run
);

    char_t      lead_reg, lead_next;
    char_t      cont0_reg, cont0_next;
    char_t      cont1_reg, cont1_next;
    logic [1:0] count_reg, count_next;

    logic       accept;
    logic [1:0] need;
    logic [1:0] have;
    logic       fresh_emit;
    logic       seq_done;

    assign s_tready   = !q_stat.full;
    assign accept     = s_tvalid && s_tready;
    assign need       = lead_need(lead_reg);
    assign have       = count_reg - 2'd1;
    assign fresh_emit = (lead_need(s_tdata) == NEED_NONE);
    assign seq_done   = ({1'b0, have} + 3'd1) >= {1'b0, need};

    always_comb
    begin
        lead_next  = lead_reg;
        cont0_next = cont0_reg;
        cont1_next = cont1_reg;
        count_next = count_reg;
        push       = 1'b0;
        push_run   = '0;
        if (accept)
        begin
            if (count_reg == HELD_NONE)
            begin
                if (fresh_emit)
                begin
                    push              = 1'b1;
                    push_run.chars[0] = s_tdata;
                    push_run.last_idx = 2'd0;
                    push_run.eot      = (s_tdata == NUL_BYTE);
                end
                else
                begin
                    lead_next  = s_tdata;
                    count_next = HELD_LEAD;
                end
            end
            else if (is_cont(s_tdata))
            begin
                if (seq_done)
                begin
                    push              = 1'b1;
                    push_run.chars[0] = (need == NEED_ONE) ?
                                        {lead_reg[1:0], s_tdata[5:0]} : repl_char;
                    push_run.last_idx = 2'd0;
                    count_next        = HELD_NONE;
                end
                else
                begin
                    if (have[0])
                        cont1_next = s_tdata;
                    else
                        cont0_next = s_tdata;
                    count_next = count_reg + 2'd1;
                end
            end
            else
            begin
                push              = 1'b1;
                push_run.chars[0] = lead_reg;
                push_run.chars[1] = (count_reg == HELD_LEAD) ? s_tdata : cont0_reg;
                push_run.chars[2] = (count_reg == HELD_ONE) ? s_tdata : cont1_reg;
                push_run.chars[3] = s_tdata;
                push_run.last_idx = fresh_emit ? count_reg : (count_reg - 2'd1);
                push_run.eot      = fresh_emit && (s_tdata == NUL_BYTE);
                if (fresh_emit)
                    count_next = HELD_NONE;
                else
                begin
                    lead_next  = s_tdata;
                    count_next = HELD_LEAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg  <= '0;
            count_reg <= HELD_NONE;
        end
        else
        begin
            lead_reg  <= lead_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cont0_reg <= cont0_next;
        cont1_reg <= cont1_next;
    end

endmodule

>>> rtl/core/u2l_queue.sv
// Short queue of result runs between the front and back parts.
// Depends on u2l_pkg.
module u2l_queue
    import u2l_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  run_t    push_run,
    input  logic    pop,
    output run_t    head,
    output q_stat_t q_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    run_t          store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_run;
    end

endmodule

>>> rtl/core/u2l_back.sv
// Back part: steps through the head run and drives one character per transfer.
// Depends on u2l_pkg.
module u2l_back
    import u2l_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  run_t       head,
    input  q_stat_t    q_stat,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tuser,
    output logic       m_tlast
);

    logic [1:0] idx_reg, idx_next;
    logic       xfer;
    logic       at_last;

    assign m_tvalid = !q_stat.empty;
    assign xfer     = m_tvalid && m_tready;
    assign at_last  = (idx_reg == head.last_idx);
    assign m_tdata  = head.chars[idx_reg];
    assign m_tlast  = at_last;
    assign m_tuser  = head.eot && at_last;
    assign pop      = xfer && at_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (xfer)
            idx_next = at_last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

>>> rtl/core/utf8_to_latin1_decoder.sv
// Top level of the UTF-8 to 8-bit character decoder: front, run queue, back.
// Depends on u2l_pkg, u2l_front, u2l_queue, u2l_back and the assertion header.
//
//  channel  direction  payload                                   handshake
//  s_*      in         tdata[7:0] in_byte                        s_tvalid/s_tready
//  m_*      out        tdata[7:0] out_char, tuser end_of_text,   m_tvalid/m_tready
//                      tlast last_of_run
//  cfg_*    in         cfg_data[7:0] replacement_char            cfg_valid/cfg_ready
//
// One byte is accepted per cycle while the run queue has room.
// A byte that yields k characters occupies the output for k transfers; runs of up
// to four characters drain from the queue head, which sets the sustained rate.
// Reset clears the held sequence, the queue and sets replacement_char to '?'.
// Input and output stall independently through the queue; cfg is always ready.
`include "utf8_to_latin1_decoder_assert.svh"

module utf8_to_latin1_decoder
    import u2l_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tuser,   // [0] end_of_text
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    char_t   repl_reg, repl_next;
    logic    push;
    run_t    push_run;
    logic    pop;
    run_t    head;
    q_stat_t q_stat;

    assign cfg_ready = 1'b1;
    assign repl_next = (cfg_valid && cfg_ready) ? cfg_data : repl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            repl_reg <= REPL_RESET;
        else
            repl_reg <= repl_next;
    end

    u2l_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .repl_char (repl_reg),
        .q_stat    (q_stat),
        .push      (push),
        .push_run  (push_run)
    );

    u2l_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    u2l_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `U2L_ASSERT_SAME(a_eot_is_nul, m_tvalid && m_tuser, m_tdata == NUL_BYTE && m_tlast, "end marker must be a zero char closing its run")
    `U2L_ASSERT_SAME(a_no_push_full, push, !q_stat.full, "run pushed into full queue")
    `U2L_ASSERT_NEXT(a_pop_empty_follow, pop && q_stat.full, !q_stat.empty && !q_stat.full, "queue count wrong after pop from full")

endmodule
